/* sv/rtpjq_pkg.sv */
package rtpjq_pkg;

	localparam int RING_SAMPLES  = 1024;
	localparam int FRAME_SAMPLES = 80;
	localparam int QUEUE_DEPTH   = 4;

	localparam int IDX_W   = $clog2(RING_SAMPLES);
	localparam int FILL_W  = $clog2(RING_SAMPLES + 1);
	localparam int FRAME_W = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;
	localparam int LEN_W   = 11;
	localparam int DROP_W  = (LEN_W > FILL_W) ? LEN_W : FILL_W;
	localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LEN_W-1:0] BPOS_MAX = {LEN_W{1'b1}};

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_MULAW = 2'd1;
	localparam logic [1:0] KIND_ALAW  = 2'd2;

	localparam logic [6:0] PTYPE_MULAW = 7'd0;
	localparam logic [6:0] PTYPE_ALAW  = 7'd8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] data;
	} cmd_t;

	function automatic logic [15:0] mulaw_to_linear(input logic [7:0] b);
		logic [7:0]  u;
		logic [15:0] t;
		u = ~b;
		t = (16'({u[3:0], 3'b000}) + 16'h0084) << u[6:4];
		return u[7] ? (16'h0084 - t) : (t - 16'h0084);
	endfunction

	function automatic logic [15:0] alaw_to_linear(input logic [7:0] b);
		logic [7:0]  a;
		logic [2:0]  seg;
		logic [15:0] t;
		a   = b ^ 8'h55;
		seg = a[6:4];
		t   = 16'({a[3:0], 4'b0000});
		if (seg == 3'd0) begin
			t = t + 16'h0008;
		end else begin
			t = (t + 16'h0108) << (seg - 3'd1);
		end
		return a[7] ? t : (16'h0000 - t);
	endfunction

	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
			input logic [IDX_W-1:0] d);
		logic [IDX_W:0] s;
		s = {1'b0, idx} + {1'b0, d};
		if (s >= (IDX_W+1)'(RING_SAMPLES)) begin
			s = s - (IDX_W+1)'(RING_SAMPLES);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

/* sv/rtp_g711_jitter_queue.sv */
// Packet bytes: one transfer per cycle while the command queue has room.
// Sample requests: each passes the command queue, the registered read port of
// the sample ring and the output register. Another request waits in the queue
// while a read is pending at the ring read port or the output is stalled.
// Reset (arst_n, async, active low) clears pointers, counts, parser and
// priming state at once; ring contents are left as they are, no clear pass.
module rtp_g711_jitter_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte[7:0], first_byte[8], packet_length[19:9], zero
	input  logic        s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // sample_out[15:0], priming_left[23:16]
	output logic        m_tuser,   // underrun
	output logic        m_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // priming_reload
);
	import rtpjq_pkg::*;

	logic [7:0] reload_q;
	logic       q_full;
	logic       q_empty;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       pop_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			reload_q <= cfg_data;
		end
	end

	rtpjq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	rtpjq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	rtpjq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (pop_cmd),
		.q_empty  (q_empty),
		.pop      (pop),
		.reload   (reload_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* sv/rtpjq_front.sv */
module rtpjq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [23:0]        s_tdata,
	input  logic               s_tuser,
	input  logic               q_full,
	output logic               push,
	output rtpjq_pkg::cmd_t    push_cmd
);
	import rtpjq_pkg::*;

	logic [LEN_W-1:0] bpos_q;
	logic [3:0]       csrc_q;
	logic [1:0]       kind_q;
	logic [LEN_W-1:0] total_q;

	logic [7:0]       data_byte;
	logic             first_byte;
	logic [LEN_W-1:0] pkt_len;
	logic             take;
	logic [LEN_W-1:0] hdr_cur;
	logic [LEN_W-1:0] hdr_new;
	logic [LEN_W-1:0] bpos_inc;
	logic [6:0]       ptype;
	logic             accept_pkt;
	logic             in_payload;

	assign data_byte  = s_tdata[7:0];
	assign first_byte = s_tdata[8];
	assign pkt_len    = s_tdata[19:9];

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	assign hdr_cur  = LEN_W'(12) + LEN_W'({csrc_q, 2'b00});
	assign hdr_new  = LEN_W'(12) + LEN_W'({data_byte[3:0], 2'b00});
	assign bpos_inc = (bpos_q < BPOS_MAX) ? bpos_q + LEN_W'(1) : bpos_q;
	assign ptype    = data_byte[6:0];
	assign accept_pkt = (ptype == PTYPE_MULAW || ptype == PTYPE_ALAW) && (total_q != '0);
	assign in_payload = (bpos_q >= hdr_cur) && ((bpos_q - hdr_cur) < total_q);

	always_comb begin
		push          = 1'b0;
		push_cmd.kind = CMD_READ;
		push_cmd.data = '0;
		if (take) begin
			if (s_tuser) begin
				push = 1'b1;
			end else if (first_byte) begin
				push = 1'b0;
			end else if (bpos_q == LEN_W'(1)) begin
				push          = accept_pkt;
				push_cmd.kind = CMD_START;
				push_cmd.data = 16'(total_q);
			end else if (kind_q != KIND_NONE && in_payload) begin
				push          = 1'b1;
				push_cmd.kind = CMD_WRITE;
				push_cmd.data = (kind_q == KIND_MULAW) ? mulaw_to_linear(data_byte)
					: alaw_to_linear(data_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpos_q  <= '0;
			csrc_q  <= '0;
			kind_q  <= KIND_NONE;
			total_q <= '0;
		end else if (take && !s_tuser) begin
			if (first_byte) begin
				csrc_q  <= data_byte[3:0];
				total_q <= (pkt_len > hdr_new) ? pkt_len - hdr_new : '0;
				kind_q  <= KIND_NONE;
				bpos_q  <= LEN_W'(1);
			end else if (bpos_q == LEN_W'(1)) begin
				if (accept_pkt) begin
					kind_q <= (ptype == PTYPE_MULAW) ? KIND_MULAW : KIND_ALAW;
				end else begin
					kind_q <= KIND_NONE;
				end
				bpos_q <= LEN_W'(2);
			end else begin
				bpos_q <= bpos_inc;
			end
		end
	end

endmodule

/* sv/rtpjq_queue.sv */
module rtpjq_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rtpjq_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output rtpjq_pkg::cmd_t pop_cmd,
	output logic            empty
);
	import rtpjq_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/rtpjq_back.sv */
module rtpjq_back (
	input  logic            clk,
	input  logic            arst_n,
	input  rtpjq_pkg::cmd_t cmd,
	input  logic            q_empty,
	output logic            pop,
	input  logic [7:0]      reload,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [23:0]     m_tdata,
	output logic            m_tuser,
	output logic            m_tlast
);
	import rtpjq_pkg::*;

	logic [15:0] ring_mem [RING_SAMPLES];
	logic [15:0] rd_data_q;

	logic [IDX_W-1:0]   widx_q, widx_n;
	logic [IDX_W-1:0]   ridx_q, ridx_n;
	logic [FILL_W-1:0]  fill_q, fill_n;
	logic [7:0]         prime_q, prime_n;
	logic [FRAME_W-1:0] fpos_q, fpos_n;
	logic               silent_q, silent_n;

	logic       pend_s1;
	logic       under_s1;
	logic       fend_s1;
	logic [7:0] prime_s1;

	logic        out_valid_q;
	logic [15:0] out_sample_q;
	logic [7:0]  out_prime_q;
	logic        out_under_q;
	logic        out_fend_q;

	logic              can_read;
	logic              wr_en;
	logic              rd_en;
	logic              under;
	logic              fend;
	logic [DROP_W-1:0] total_w;
	logic [DROP_W-1:0] drop;
	logic [IDX_W-1:0]  drop_idx;

	assign can_read = !pend_s1 && (!out_valid_q || m_tready);
	assign pop      = !q_empty && ((cmd.kind != CMD_READ) || can_read);

	assign total_w  = DROP_W'(cmd.data[LEN_W-1:0]);
	assign drop     = (total_w < DROP_W'(RING_SAMPLES)) ? total_w : DROP_W'(RING_SAMPLES);
	assign drop_idx = (drop == DROP_W'(RING_SAMPLES)) ? '0 : IDX_W'(drop);

	always_comb begin
		widx_n   = widx_q;
		ridx_n   = ridx_q;
		fill_n   = fill_q;
		prime_n  = prime_q;
		fpos_n   = fpos_q;
		silent_n = silent_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		under    = 1'b0;
		fend     = 1'b0;
		if (pop) begin
			case (cmd.kind)
				CMD_START: begin
					if (prime_q != '0) begin
						prime_n = prime_q - 8'd1;
					end
					if (fill_q == FILL_W'(RING_SAMPLES)) begin
						ridx_n = wrap_add(widx_q, drop_idx);
						fill_n = fill_q - FILL_W'(drop);
					end
				end
				CMD_WRITE: begin
					wr_en  = 1'b1;
					widx_n = wrap_add(widx_q, IDX_W'(1));
					if (fill_q >= FILL_W'(RING_SAMPLES)) begin
						fill_n = FILL_W'(RING_SAMPLES);
						ridx_n = wrap_add(ridx_q, IDX_W'(1));
					end else begin
						fill_n = fill_q + FILL_W'(1);
					end
				end
				CMD_READ: begin
					if (fpos_q == '0) begin
						silent_n = (fill_q == '0);
						if (fill_q == '0) begin
							prime_n = reload;
						end
					end
					under = silent_n || (fill_q == '0);
					if (!under) begin
						rd_en  = 1'b1;
						ridx_n = wrap_add(ridx_q, IDX_W'(1));
						fill_n = fill_q - FILL_W'(1);
					end
					fend   = (fpos_q == FRAME_W'(FRAME_SAMPLES - 1));
					fpos_n = fend ? '0 : fpos_q + FRAME_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[widx_q] <= cmd.data;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[ridx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q      <= '0;
			ridx_q      <= '0;
			fill_q      <= '0;
			prime_q     <= '0;
			fpos_q      <= '0;
			silent_q    <= 1'b0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			widx_q   <= widx_n;
			ridx_q   <= ridx_n;
			fill_q   <= fill_n;
			prime_q  <= prime_n;
			fpos_q   <= fpos_n;
			silent_q <= silent_n;
			pend_s1  <= pop && (cmd.kind == CMD_READ);
			if (pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.kind == CMD_READ) begin
			under_s1 <= under;
			fend_s1  <= fend;
			prime_s1 <= prime_n;
		end
		if (pend_s1) begin
			out_sample_q <= under_s1 ? 16'h0000 : rd_data_q;
			out_under_q  <= under_s1;
			out_fend_q   <= fend_s1;
			out_prime_q  <= prime_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_prime_q, out_sample_q};
	assign m_tuser  = out_under_q;
	assign m_tlast  = out_fend_q;

endmodule

/* sv/rtpjq_checker.sv */
module rtpjq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [7:0]  cfg_data
);
	import rtpjq_pkg::*;

	logic [7:0]         reload_q;
	logic [FRAME_W-1:0] frm_cnt_q;
	logic               out_xfer;
	logic               last_pos;

	assign out_xfer = m_tvalid && m_tready;
	assign last_pos = (frm_cnt_q == FRAME_W'(FRAME_SAMPLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q  <= '0;
			frm_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				reload_q <= cfg_data;
			end
			if (out_xfer) begin
				frm_cnt_q <= last_pos ? '0 : frm_cnt_q + FRAME_W'(1);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output changed while stalled");

	a_underrun_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[15:0] == 16'h0000)
		else $error("underrun sample not zero");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> m_tlast == last_pos)
		else $error("frame end misplaced");

	a_silent_reload: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && m_tuser && frm_cnt_q == '0 |-> m_tdata[23:16] == reload_q)
		else $error("silent frame did not reload priming count");

endmodule

bind rtp_g711_jitter_queue rtpjq_checker u_chk (.*);

/* verif/jq_tb_pkg.sv */
`timescale 1ns / 100ps
package jq_tb_pkg;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_READ = 1'b1;

	localparam logic [6:0] PT_MULAW = 7'd0;
	localparam logic [6:0] PT_ALAW  = 7'd8;

	localparam int RTP_FIXED_HDR = 12;

	typedef struct packed {
		logic [15:0] pcm;
		logic        frame_end;
		logic        underrun;
		logic [7:0]  priming;
	} audio_sample_t;

	function automatic int rtp_header_bytes(input logic [3:0] cc);
		return RTP_FIXED_HDR + 4 * int'(cc);
	endfunction

endpackage

/* verif/jitter_queue_checker.sv */
`timescale 1ns / 100ps
module jitter_queue_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte[7:0], first_byte[8], packet_length[19:9], zero
	input  logic        s_tuser,   // mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // sample_out[15:0], priming_left[23:16]
	input  logic        m_tuser,   // underrun
	input  logic        m_tlast,   // frame_end
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          failures,
	output int          pending
);
	import rtpjq_pkg::*;
	import jq_tb_pkg::*;

	localparam int MAX_REPORTS = 10;
	localparam int MULAW_BIAS  = 132;
	localparam int ALAW_STEP   = 264;

	logic [15:0]   ring [RING_SAMPLES];
	int            wr_ptr    = 0;
	int            rd_ptr    = 0;
	int            level     = 0;
	int            prime     = 0;
	int            bpos      = 0;
	int            pay_total = 0;
	int            fpos      = 0;
	logic [7:0]    reload    = '0;
	logic [3:0]    csrc      = '0;
	logic [1:0]    kind      = KIND_NONE;
	logic          silent    = 1'b0;
	audio_sample_t expected_q[$];

	function automatic logic [15:0] expand_mulaw(input logic [7:0] code);
		logic [7:0] inv;
		int mag;
		inv = ~code;
		mag = ((int'(inv[3:0]) << 3) + MULAW_BIAS) << inv[6:4];
		return inv[7] ? 16'(MULAW_BIAS - mag) : 16'(mag - MULAW_BIAS);
	endfunction

	function automatic logic [15:0] expand_alaw(input logic [7:0] code);
		logic [7:0] a;
		int mag;
		a = code ^ 8'h55;
		mag = int'(a[3:0]) << 4;
		if (a[6:4] == 3'd0) begin
			mag = mag + 8;
		end else begin
			mag = (mag + ALAW_STEP) << (int'(a[6:4]) - 1);
		end
		return a[7] ? 16'(mag) : 16'(-mag);
	endfunction

	function automatic void absorb_byte(input logic [7:0] data, input logic first,
			input logic [10:0] len);
		int hdr;
		int drop;
		hdr = rtp_header_bytes(csrc);
		if (first) begin
			csrc = data[3:0];
			hdr = rtp_header_bytes(data[3:0]);
			pay_total = (int'(len) > hdr) ? int'(len) - hdr : 0;
			kind = KIND_NONE;
			bpos = 1;
		end else if (bpos == 1) begin
			kind = KIND_NONE;
			if ((data[6:0] == PT_MULAW || data[6:0] == PT_ALAW) && pay_total != 0) begin
				kind = (data[6:0] == PT_MULAW) ? KIND_MULAW : KIND_ALAW;
				if (prime > 0) prime--;
				// ring exactly full: make room for this packet's payload
				if (level == RING_SAMPLES) begin
					drop = (pay_total < RING_SAMPLES) ? pay_total : RING_SAMPLES;
					rd_ptr = (wr_ptr + drop) % RING_SAMPLES;
					level = level - drop;
				end
			end
			bpos = 2;
		end else begin
			if (kind != KIND_NONE && bpos >= hdr && bpos - hdr < pay_total) begin
				ring[wr_ptr] = (kind == KIND_MULAW) ? expand_mulaw(data) : expand_alaw(data);
				wr_ptr = (wr_ptr + 1) % RING_SAMPLES;
				if (level >= RING_SAMPLES) begin
					rd_ptr = (rd_ptr + 1) % RING_SAMPLES;
				end else begin
					level++;
				end
			end
			if (bpos < int'(BPOS_MAX)) bpos++;
		end
	endfunction

	function automatic audio_sample_t take_sample();
		audio_sample_t r;
		r = '0;
		if (fpos == 0) begin
			silent = (level == 0);
			if (silent) prime = int'(reload);
		end
		if (silent || level == 0) begin
			r.underrun = 1'b1;
		end else begin
			r.pcm = ring[rd_ptr];
			rd_ptr = (rd_ptr + 1) % RING_SAMPLES;
			level--;
		end
		r.frame_end = (fpos + 1 >= FRAME_SAMPLES);
		fpos = r.frame_end ? 0 : fpos + 1;
		r.priming = 8'(prime);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		audio_sample_t got;
		audio_sample_t want;
		if (!arst_n) begin
			wr_ptr = 0;
			rd_ptr = 0;
			level = 0;
			prime = 0;
			bpos = 0;
			pay_total = 0;
			fpos = 0;
			reload = '0;
			csrc = '0;
			kind = KIND_NONE;
			silent = 1'b0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[15:0], m_tlast, m_tuser, m_tdata[23:16]};
				if (expected_q.size() == 0) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("%0t: unexpected sample %h end %b underrun %b priming %0d",
							$realtime, got.pcm, got.frame_end, got.underrun, got.priming);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= MAX_REPORTS) begin
							$write("%0t: sample mismatch: expected %h end %b underrun %b ",
								$realtime, want.pcm, want.frame_end, want.underrun);
							$display("priming %0d, got %h end %b underrun %b priming %0d",
								want.priming, got.pcm, got.frame_end, got.underrun,
								got.priming);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) reload = cfg_data;
			if (s_tvalid && s_tready) begin
				if (s_tuser == MODE_READ) begin
					expected_q.push_back(take_sample());
				end else begin
					absorb_byte(s_tdata[7:0], s_tdata[8], s_tdata[19:9]);
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
module testbench;
	import rtpjq_pkg::*;
	import jq_tb_pkg::*;

	localparam int SQUEEZE_CYCLES = 400;
	localparam int DRAIN_CYCLES   = 20;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;

	int failures;
	int pending;
	int audio_items = 0;
	bit steady      = 1'b0;
	bit squeeze_req = 1'b0;

	rtp_g711_jitter_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	jitter_queue_checker check_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.failures  (failures),
		.pending   (pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic mode, input logic [7:0] data, input logic first,
			input logic [10:0] len);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {4'b0000, len, first, data};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		gap = idle_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_request();
		send_item(MODE_READ, 8'($urandom), 1'($urandom), 11'($urandom));
		audio_items++;
	endtask

	task automatic send_packet(input logic [3:0] cc, input logic [7:0] pt_byte,
			input logic [10:0] len_field, input int n_bytes, input int read_pct,
			input bit tally);
		logic [7:0] b;
		for (int i = 0; i < n_bytes; i++) begin
			if ($urandom_range(0, 99) < read_pct) send_request();
			if (i == 0) b = {4'($urandom), cc};
			else if (i == 1) b = pt_byte;
			else b = 8'($urandom);
			send_item(MODE_BYTE, b, i == 0, (i == 0) ? len_field : 11'($urandom));
			if (tally) audio_items++;
		end
	endtask

	task automatic write_reload(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_traffic(input int n, input int read_pct);
		int goal;
		int pick;
		int pay;
		int cut;
		logic [3:0] cc;
		logic [7:0] pt;
		goal = audio_items + n;
		while (audio_items < goal) begin
			pick = $urandom_range(0, 99);
			cc = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
			if (pick < 78) begin
				pt = {1'($urandom), ($urandom_range(0, 3) == 0) ? PT_ALAW : PT_MULAW};
				pay = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 300)
					: $urandom_range(1, 40);
				cut = rtp_header_bytes(cc) + pay;
				if ($urandom_range(0, 9) == 0) cut = $urandom_range(2, cut);
				else if ($urandom_range(0, 19) == 0) cut = cut + $urandom_range(1, 6);
				send_packet(cc, pt, 11'(rtp_header_bytes(cc) + pay), cut, read_pct, 1'b1);
			end else if (pick < 88) begin
				send_packet(cc, 8'($urandom), 11'($urandom), $urandom_range(1, 30),
					read_pct, 1'b0);
			end else if (pick < 93) begin
				repeat ($urandom_range(1, 4))
					send_item(MODE_BYTE, 8'($urandom), 1'b0, 11'($urandom));
			end else begin
				repeat ($urandom_range(1, 90)) send_request();
			end
		end
	endtask

	task automatic ring_overflow();
		// truncated packet longer than the ring: fill saturates, oldest samples overwritten
		send_packet(4'd0, {1'b0, PT_MULAW}, BPOS_MAX,
			rtp_header_bytes(4'd0) + RING_SAMPLES + 4, 0, 1'b1);
		// ring exactly full at packet start: payload's worth of oldest samples dropped
		send_packet(4'd0, {1'b1, PT_ALAW}, 11'(rtp_header_bytes(4'd0) + 30),
			rtp_header_bytes(4'd0) + 30, 0, 1'b1);
		// full again; declared payload above ring size empties it
		send_packet(4'd3, {1'b0, PT_MULAW}, BPOS_MAX, rtp_header_bytes(4'd3) + 8, 0, 1'b1);
		repeat (FRAME_SAMPLES) send_request();
	endtask

	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				m_tready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end else begin
				gap = idle_gap();
				if (gap != 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reload(8'hFF);
		send_request();
		send_item(MODE_BYTE, 8'hF0, 1'b1, 11'(rtp_header_bytes(4'd0) + 4));
		send_item(MODE_BYTE, {1'b1, PT_MULAW}, 1'b0, '0);
		repeat (RTP_FIXED_HDR - 2) send_item(MODE_BYTE, 8'($urandom), 1'b0, 11'($urandom));
		send_item(MODE_BYTE, 8'h00, 1'b0, '0);
		send_item(MODE_BYTE, 8'hFF, 1'b0, '0);
		send_item(MODE_BYTE, 8'h7F, 1'b0, '0);
		send_item(MODE_BYTE, 8'h80, 1'b0, '0);
		send_item(MODE_BYTE, 8'hAA, 1'b0, BPOS_MAX);
		send_item(MODE_BYTE, 8'h00, 1'b1, 11'd5);
		send_item(MODE_BYTE, {1'b0, PT_ALAW}, 1'b0, '0);
		repeat (3) send_request();
		settle();

		write_reload(8'h00);
		squeeze_req = 1'b1;
		random_traffic(100, 40);
		settle();

		write_reload(8'($urandom_range(1, 254)));
		ring_overflow();
		random_traffic(30, 12);
		settle();

		write_reload(8'hFF);
		steady = 1'b1;
		random_traffic(60, 25);
		steady = 1'b0;
		settle();

		write_reload(8'h00);
		random_traffic(30, 30);
		settle();

		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* rtp_g711_jitter_queue.f */
sv/rtpjq_pkg.sv
sv/rtpjq_front.sv
sv/rtpjq_queue.sv
sv/rtpjq_back.sv
sv/rtp_g711_jitter_queue.sv
sv/rtpjq_checker.sv
verif/jq_tb_pkg.sv
verif/jitter_queue_checker.sv
verif/testbench.sv
